// File: rtl/core/facl_pkg.sv
// ----------------------------------------------------------------------------
// facl_pkg
// Shared types and constants for the fully associative cache lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package facl_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS  = 2'd2;

    localparam logic       MODE_FIFO = 1'b0;
    localparam logic       MODE_LRU  = 1'b1;

    localparam logic [4:0] LINE_COUNT_RST  = 5'd16;
    localparam logic [3:0] OFFSET_BITS_RST = 4'd4;

    // lookup outcome handed from the sequencer to the output stage
    typedef struct packed {
        logic done;
        logic hit;
    } facl_result_t;

endpackage : facl_pkg

`default_nettype wire

// File: rtl/core/facl_tag_ram.sv
// ----------------------------------------------------------------------------
// facl_tag_ram
// Tag storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module facl_tag_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : facl_tag_ram

`default_nettype wire

// File: rtl/core/facl_seq.sv
// ----------------------------------------------------------------------------
// facl_seq
// Lookup sequencer: walks the tag list oldest first through one comparator,
// then shifts, appends and trims the list, kept as a ring in the tag RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module facl_seq
    import facl_pkg::*;
#(
    parameter int LINES     = 16,
    parameter int TAG_W     = 32,
    parameter int IDX_W     = 4,
    parameter int OCC_W     = 5
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [TAG_W-1:0] tag,
    input  wire logic             replace_mode,
    input  wire logic [OCC_W-1:0] cap,
    input  wire logic             out_ok,
    output logic                  idle,
    output facl_result_t          result,
    output logic                  mem_we,
    output logic      [IDX_W-1:0] mem_waddr,
    output logic      [TAG_W-1:0] mem_wdata,
    output logic      [IDX_W-1:0] mem_raddr,
    input  wire logic [TAG_W-1:0] mem_rdata
);

    localparam int SUM_W = OCC_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_APPEND,
        S_TRIM,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [OCC_W-1:0]   idx_reg, idx_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic               hit_reg, hit_next;
    logic [OCC_W-1:0]   idx_inc;

    // logical list position to RAM address
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [OCC_W-1:0] pos);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(pos);
        if (sum >= SUM_W'(LINES))
        begin
            sum = sum - SUM_W'(LINES);
        end
        return IDX_W'(sum);
    endfunction

    assign idx_inc = idx_reg + OCC_W'(1);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        occ_next   = occ_reg;
        idx_next   = idx_reg;
        tag_next   = tag_reg;
        hit_next   = hit_reg;
        mem_we     = 1'b0;
        mem_waddr  = phys(head_reg, idx_reg);
        mem_wdata  = tag_reg;
        mem_raddr  = phys(head_reg, idx_inc);

        unique case (state_reg)
            S_IDLE:
            begin
                mem_raddr = head_reg;
                if (start)
                begin
                    tag_next = tag;
                    idx_next = '0;
                    hit_next = 1'b0;
                    state_next = (occ_reg == '0) ? S_APPEND : S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (mem_rdata == tag_reg)
                begin
                    hit_next   = 1'b1;
                    state_next = (replace_mode == MODE_LRU) ? S_SHIFT_RD : S_TRIM;
                end
                else if (idx_inc < occ_reg)
                begin
                    idx_next = idx_inc;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_SHIFT_RD:
            begin
                if (idx_inc < occ_reg)
                begin
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    // hit tag moves to the newest end
                    mem_we     = 1'b1;
                    state_next = S_TRIM;
                end
            end
            S_SHIFT_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                idx_next   = idx_inc;
                state_next = S_SHIFT_RD;
            end
            S_APPEND:
            begin
                mem_we = 1'b1;
                if (occ_reg == OCC_W'(LINES))
                begin
                    // full: overwrite the oldest slot and advance the head
                    mem_waddr = head_reg;
                    head_next = phys(head_reg, OCC_W'(1));
                end
                else
                begin
                    mem_waddr = phys(head_reg, occ_reg);
                    occ_next  = occ_reg + OCC_W'(1);
                end
                state_next = S_TRIM;
            end
            S_TRIM:
            begin
                if (occ_reg > cap)
                begin
                    head_next = phys(head_reg, OCC_W'(1));
                    occ_next  = occ_reg - OCC_W'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            occ_reg   <= '0;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            occ_reg   <= occ_next;
            idx_reg   <= idx_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

    assign idle        = (state_reg == S_IDLE);
    assign result.done = (state_reg == S_DONE) && out_ok;
    assign result.hit  = hit_reg;

endmodule : facl_seq

`default_nettype wire

// File: rtl/core/fully_assoc_cache_lookup.sv
// ----------------------------------------------------------------------------
// fully_assoc_cache_lookup
// Fully associative tag lookup with FIFO or LRU replacement and hit/miss totals.
// ----------------------------------------------------------------------------
// One address item is handled at a time. The tag list lives in a single-port
// read / single-port write RAM and is scanned one entry per cycle through one
// comparator, oldest first. A miss then appends the tag and trims the list; a
// FIFO hit goes straight to the trim. The next item can be accepted once the
// result has been moved into the output register. An LRU hit first reads and
// rewrites each entry newer than the hit one place toward the oldest end, then
// writes the hit tag at the newest end. Lowering line_count below the current
// fill makes the trim of the next item evict oldest entries until the fill fits.
// in_stall stays high while an item is in flight; a finished result sits in
// the output register until taken. Tags reset to no valid entries.
// ----------------------------------------------------------------------------
`default_nettype none

module fully_assoc_cache_lookup
    import facl_pkg::*;
#(
    parameter int LINES     = 16,
    parameter int ADDR_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [ADDR_BITS-1:0]  address,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       hit,
    output logic [31:0]                hit_count,
    output logic [31:0]                miss_count,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int OCC_W = $clog2(LINES + 1);
    localparam int CMP_W = (OCC_W > 5) ? OCC_W : 5;

    logic                 replace_mode_reg;
    logic [4:0]           line_count_reg;
    logic [3:0]           offset_bits_reg;
    logic                 out_valid_reg;
    logic                 hit_reg;
    logic [31:0]          hit_count_reg;
    logic [31:0]          miss_count_reg;

    logic [ADDR_BITS-1:0] tag;
    logic [CMP_W-1:0]     lc_ext;
    logic [OCC_W-1:0]     cap;
    logic                 seq_idle;
    logic                 out_ok;
    facl_result_t         result;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [ADDR_BITS-1:0] mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;
    logic [ADDR_BITS-1:0] mem_rdata;

    assign cfg_ready = 1'b1;
    assign in_stall  = !seq_idle;
    assign out_ok    = !out_valid_reg || !out_stall;
    assign tag       = address >> offset_bits_reg;

    always_comb
    begin
        lc_ext = CMP_W'(line_count_reg);
        if (lc_ext == '0)
        begin
            cap = OCC_W'(1);
        end
        else if (lc_ext > CMP_W'(LINES))
        begin
            cap = OCC_W'(LINES);
        end
        else
        begin
            cap = OCC_W'(lc_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            replace_mode_reg <= MODE_FIFO;
            line_count_reg   <= LINE_COUNT_RST;
            offset_bits_reg  <= OFFSET_BITS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_REPLACE_MODE: replace_mode_reg <= cfg_data[0];
                CFG_LINE_COUNT:   line_count_reg   <= cfg_data[4:0];
                CFG_OFFSET_BITS:  offset_bits_reg  <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hit_count_reg  <= '0;
            miss_count_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (result.done)
            begin
                out_valid_reg <= 1'b1;
                if (result.hit)
                begin
                    if (hit_count_reg != '1)
                    begin
                        hit_count_reg <= hit_count_reg + 32'd1;
                    end
                end
                else if (miss_count_reg != '1)
                begin
                    miss_count_reg <= miss_count_reg + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.done)
        begin
            hit_reg <= result.hit;
        end
    end

    facl_seq #(
        .LINES (LINES),
        .TAG_W (ADDR_BITS),
        .IDX_W (IDX_W),
        .OCC_W (OCC_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (in_valid),
        .tag          (tag),
        .replace_mode (replace_mode_reg),
        .cap          (cap),
        .out_ok       (out_ok),
        .idle         (seq_idle),
        .result       (result),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    facl_tag_ram #(
        .DEPTH (LINES),
        .WIDTH (ADDR_BITS),
        .AW    (IDX_W)
    ) u_tag_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign hit_count  = hit_count_reg;
    assign miss_count = miss_count_reg;

endmodule : fully_assoc_cache_lookup

`default_nettype wire

// File: sim/tb_fully_assoc_cache_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fully_assoc_cache_lookup
// Self-checking bench for the fully associative cache lookup block.
// ----------------------------------------------------------------------------
// A queue of address items feeds a clocked driver. The driver runs a local
// FIFO/LRU tag list model on every accepted item. A clocked monitor checks each
// result against the oldest prediction. Directed items cover the address
// extremes, the line count clamp and trim, and large offsets. Random phases
// then sweep the replacement mode, line count, offset and idle patterns, and
// one phase holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------

module tb_fully_assoc_cache_lookup;
    import facl_pkg::*;

    localparam int LINES       = 16;
    localparam int ADDR_BITS   = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_LEN    = 300;
    localparam int PHASE_ITEMS = 200;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct packed {
        logic        hit;
        logic [31:0] hits;
        logic [31:0] misses;
    } lookup_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [ADDR_BITS-1:0]  address = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  hit;
    logic [31:0]           hit_count;
    logic [31:0]           miss_count;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    fully_assoc_cache_lookup #(
        .LINES     (LINES),
        .ADDR_BITS (ADDR_BITS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .address    (address),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hit        (hit),
        .hit_count  (hit_count),
        .miss_count (miss_count),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    logic [ADDR_BITS-1:0] addr_queue[$];
    lookup_result_t       lookup_queue[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int err_count     = 0;
    int cycle_count   = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_cnt      = 0;

    // tag list model, oldest entry at index 0
    logic [ADDR_BITS-1:0] tag_store [LINES];
    int unsigned          fill = 0;
    logic [31:0]          hit_total = '0;
    logic [31:0]          miss_total = '0;
    logic                 mode_q = MODE_FIFO;
    logic [4:0]           lines_q = LINE_COUNT_RST;
    logic [3:0]           offs_q = OFFSET_BITS_RST;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned cache_capacity();
        if (lines_q == 0)
            return 1;
        if (lines_q > LINES)
            return LINES;
        return lines_q;
    endfunction

    task automatic drop_tag(input int unsigned pos);
        for (int unsigned i = pos; i + 1 < fill; i++)
            tag_store[i] = tag_store[i + 1];
        if (fill > 0)
            fill--;
    endtask

    task automatic push_tag(input logic [ADDR_BITS-1:0] tag);
        if (fill >= LINES)
            drop_tag(0);
        tag_store[fill] = tag;
        fill++;
    endtask

    task automatic lookup_predict(input logic [ADDR_BITS-1:0] addr,
                                  output lookup_result_t res);
        logic [ADDR_BITS-1:0] tag;
        int unsigned          pos;
        logic                 found;
        tag   = addr >> offs_q;
        pos   = 0;
        found = 1'b0;
        for (int unsigned i = 0; i < fill; i++)
        begin
            if (!found && tag_store[i] == tag)
            begin
                found = 1'b1;
                pos   = i;
            end
        end
        if (found)
        begin
            if (mode_q == MODE_LRU)
            begin
                drop_tag(pos);
                push_tag(tag);
            end
            if (hit_total != '1)
                hit_total++;
        end
        else
        begin
            push_tag(tag);
            if (miss_total != '1)
                miss_total++;
        end
        while (fill > cache_capacity())
            drop_tag(0);
        res.hit    = found;
        res.hits   = hit_total;
        res.misses = miss_total;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (err_count < 40)
            $display("%0t mismatch %s: expected %0h, got %0h", $time, what, want, got);
        err_count++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_REPLACE_MODE: mode_q  = data[0];
            CFG_LINE_COUNT:   lines_q = data[4:0];
            CFG_OFFSET_BITS:  offs_q  = data[3:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        do @(posedge clk);
        while (addr_queue.size() != 0 || in_valid || lookup_queue.size() != 0);
    endtask

    // driver
    always @(posedge clk)
    begin
        lookup_result_t res;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                lookup_predict(address, res);
                lookup_queue.insert(lookup_queue.size(), res);
            end
            if (!in_valid || !in_stall)
            begin
                if (addr_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    address  <= addr_queue[0];
                    addr_queue.delete(0);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long output hold-off
    always @(posedge clk)
    begin
        if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_cnt  <= HOLD_LEN;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (lookup_queue.size() == 0)
                    report_mismatch("result with none pending", '0, hit_count);
                else
                begin
                    want = lookup_queue[0];
                    lookup_queue.delete(0);
                    if (hit !== want.hit)
                        report_mismatch("hit", 32'(want.hit), 32'(hit));
                    if (hit_count !== want.hits)
                        report_mismatch("hit_count", want.hits, hit_count);
                    if (miss_count !== want.misses)
                        report_mismatch("miss_count", want.misses, miss_count);
                end
            end
            out_stall <= (hold_cnt != 0) || ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_fully_assoc_cache_lookup: FAIL");
            $finish;
        end
    end

    initial begin
        logic [ADDR_BITS-1:0] pool [LINES + 3];
        logic [ADDR_BITS-1:0] low_mask;
        int unsigned          pool_n;
        int                   pick;
        int                   ph_mode  [8] = '{0, 1, 0, 1, 1, 0, 1, 0};
        int                   ph_lines [8] = '{16, 16, 1, 4, 0, 31, 8, 5};
        int                   ph_offs  [8] = '{4, 0, 12, 15, 3, 13, 2, 7};
        int                   idle_send[4] = '{0, 45, 0, 37};
        int                   idle_recv[4] = '{0, 0, 45, 37};
        logic [3:0]           junk;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: FIFO, 16 lines, 4 offset bits
        addr_queue = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_000F,
                       32'h0000_0010, 32'hFFFF_FFF0};
        drain();

        // zero line count acts as one line
        cfg_write(CFG_LINE_COUNT, 5'd0);
        addr_queue = '{32'h0000_0100, 32'h0000_0100, 32'h0000_0200, 32'h0000_0100};
        drain();

        // line count above capacity clamps, LRU, whole address as tag
        cfg_write(CFG_LINE_COUNT, 5'd31);
        cfg_write(CFG_REPLACE_MODE, 5'b1111_1);
        cfg_write(CFG_OFFSET_BITS, 5'd0);
        addr_queue = '{32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd1};
        drain();

        // line count lowered below fill trims the oldest entries
        cfg_write(CFG_LINE_COUNT, 5'd2);
        addr_queue = '{32'd6, 32'd2};
        drain();

        // offsets above 12
        cfg_write(CFG_REPLACE_MODE, 5'b1010_0);
        cfg_write(CFG_OFFSET_BITS, 5'd15);
        addr_queue = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_7FFF};
        drain();
        cfg_write(CFG_OFFSET_BITS, 5'b1_1101);
        addr_queue = '{32'h1234_5678, 32'h0000_1FFF};
        drain();

        // unused register index is ignored
        cfg_write(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
        addr_queue = '{32'h0000_0000};
        drain();

        for (int p = 0; p < 8; p++)
        begin
            junk = 4'($urandom);
            cfg_write(CFG_REPLACE_MODE, {junk, ph_mode[p][0]});
            cfg_write(CFG_LINE_COUNT, 5'(ph_lines[p]));
            cfg_write(CFG_OFFSET_BITS, {1'($urandom), 4'(ph_offs[p])});
            send_idle_pct = idle_send[p % 4];
            stall_pct     = idle_recv[p % 4];

            pool_n   = cache_capacity() + 3;
            low_mask = (32'd1 << offs_q) - 32'd1;
            for (int k = 0; k < pool_n; k++)
                pool[k] = $urandom >> offs_q;
            pool[0] = '1 >> offs_q;
            pool[1] = '0;

            if (p == 4)
                hold_req++;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                    addr_queue.insert(addr_queue.size(),
                                      (pool[$urandom_range(pool_n - 1)] << offs_q)
                                      | ($urandom & low_mask));
                else if (pick < 95)
                    addr_queue.insert(addr_queue.size(), $urandom);
                else
                    addr_queue.insert(addr_queue.size(), $urandom_range(1) ? '1 : '0);
            end
            drain();
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (LINES + 8) @(posedge clk);
        if (lookup_queue.size() != 0)
            report_mismatch("results never seen", lookup_queue.size(), '0);

        if (err_count == 0)
            $display("tb_fully_assoc_cache_lookup: PASS");
        else
            $display("tb_fully_assoc_cache_lookup: FAIL");
        $finish;
    end

endmodule
